// ----- sv/kbt_pkg.sv -----
`default_nettype none

package kbt_pkg;

    localparam int TableLen = 84;

    // configuration register indexes
    localparam logic CFG_BUFFER_START = 1'b0;
    localparam logic CFG_BUFFER_END   = 1'b1;

    localparam logic [15:0] BUFFER_START_RST = 16'd30;
    localparam logic [15:0] BUFFER_END_RST   = 16'd62;

    // scan codes with a job of their own
    localparam logic [7:0] SC_OVERRUN   = 8'hff;
    localparam logic [7:0] SC_BREAK     = 8'h80;
    localparam logic [7:0] SC_CTRL      = 8'h1d;
    localparam logic [7:0] SC_LSHIFT    = 8'h2a;
    localparam logic [7:0] SC_RSHIFT    = 8'h36;
    localparam logic [7:0] SC_ALT       = 8'h38;
    localparam logic [7:0] SC_CAPS      = 8'h3a;
    localparam logic [7:0] SC_NUM       = 8'h45;
    localparam logic [7:0] SC_SCROLL    = 8'h46;
    localparam logic [7:0] SC_KEYPAD_LO = 8'h47;
    localparam logic [7:0] SC_KEYPAD_HI = 8'h53;

    // shift_flags bits
    localparam int FL_RSHIFT = 0;
    localparam int FL_LSHIFT = 1;
    localparam int FL_CTRL   = 2;
    localparam int FL_ALT    = 3;
    localparam int FL_SCROLL = 4;
    localparam int FL_NUM    = 5;
    localparam int FL_CAPS   = 6;

    // lock held bits
    localparam int HL_SCROLL = 0;
    localparam int HL_NUM    = 1;
    localparam int HL_CAPS   = 2;

    typedef struct packed {
        logic [7:0]  scan_code;
        logic [15:0] head_offset;
    } t_kbt_in;

    typedef struct packed {
        logic [15:0] key_code;
        logic        key_valid;
        logic [15:0] write_offset;
        logic        buffer_full;
        logic        overrun;
        logic [7:0]  shift_flags;
        logic        lock_toggled;
    } t_kbt_out;

    // decode result handed from the key decoder to the top level
    typedef struct packed {
        logic [15:0] key;
        logic [7:0]  flags;
        logic [2:0]  held;
        logic        toggled;
        logic        overrun;
    } t_kbt_dec;

    // ring write status
    typedef struct packed {
        logic        valid;
        logic [15:0] offset;
        logic        full;
    } t_kbt_wr;

    localparam logic [15:0] TBL_PLAIN [TableLen] = '{
        16'h0000, 16'h011b, 16'h0231, 16'h0332, 16'h0433, 16'h0534, 16'h0635, 16'h0736,
        16'h0837, 16'h0938, 16'h0a39, 16'h0b30, 16'h0c2d, 16'h0d3d, 16'h0e08, 16'h0f09,
        16'h1071, 16'h1177, 16'h1265, 16'h1372, 16'h1474, 16'h1579, 16'h1675, 16'h1769,
        16'h186f, 16'h1970, 16'h1a5b, 16'h1b5d, 16'h1c0d, 16'h0000, 16'h1e61, 16'h1f73,
        16'h2064, 16'h2166, 16'h2267, 16'h2368, 16'h246a, 16'h256b, 16'h266c, 16'h273b,
        16'h2827, 16'h2960, 16'h0000, 16'h2b5c, 16'h2c7a, 16'h2d78, 16'h2e63, 16'h2f76,
        16'h3062, 16'h316e, 16'h326d, 16'h332c, 16'h342e, 16'h352f, 16'h0000, 16'h372a,
        16'h0000, 16'h3920, 16'h0000, 16'h3b00, 16'h3c00, 16'h3d00, 16'h3e00, 16'h3f00,
        16'h4000, 16'h4100, 16'h4200, 16'h4300, 16'h4400, 16'h0000, 16'h0000, 16'h4700,
        16'h4800, 16'h4900, 16'h4a2d, 16'h4b00, 16'h4c00, 16'h4d00, 16'h4e2b, 16'h4f00,
        16'h5000, 16'h5100, 16'h5200, 16'h5300
    };

    localparam logic [15:0] TBL_SHIFT [TableLen] = '{
        16'h0000, 16'h011b, 16'h0221, 16'h0340, 16'h0423, 16'h0524, 16'h0625, 16'h075e,
        16'h0826, 16'h092a, 16'h0a28, 16'h0b29, 16'h0c5f, 16'h0d2b, 16'h0e08, 16'h0f00,
        16'h1051, 16'h1157, 16'h1245, 16'h1352, 16'h1454, 16'h1559, 16'h1655, 16'h1749,
        16'h184f, 16'h1950, 16'h1a7b, 16'h1b7d, 16'h1c0d, 16'h0000, 16'h1e41, 16'h1f53,
        16'h2044, 16'h2146, 16'h2247, 16'h2348, 16'h244a, 16'h254b, 16'h264c, 16'h273a,
        16'h2822, 16'h297e, 16'h0000, 16'h2b7c, 16'h2c5a, 16'h2d58, 16'h2e43, 16'h2f56,
        16'h3042, 16'h314e, 16'h324d, 16'h333c, 16'h343e, 16'h353f, 16'h0000, 16'h0000,
        16'h0000, 16'h3920, 16'h0000, 16'h5400, 16'h5500, 16'h5600, 16'h5700, 16'h5800,
        16'h5900, 16'h5a00, 16'h5b00, 16'h5c00, 16'h5d00, 16'h0000, 16'h0000, 16'h4737,
        16'h4838, 16'h4939, 16'h4a2d, 16'h4b34, 16'h4c35, 16'h4d36, 16'h4e2b, 16'h4f31,
        16'h5032, 16'h5133, 16'h5230, 16'h532e
    };

    localparam logic [15:0] TBL_CTRL [TableLen] = '{
        16'h0000, 16'h011b, 16'h0000, 16'h0300, 16'h0000, 16'h0000, 16'h0000, 16'h071e,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0c1f, 16'h0000, 16'h0e7f, 16'h9400,
        16'h1011, 16'h1117, 16'h1205, 16'h1312, 16'h1414, 16'h1519, 16'h1615, 16'h1709,
        16'h180f, 16'h1910, 16'h1a1b, 16'h1b1d, 16'h1c0a, 16'h0000, 16'h1e01, 16'h1f13,
        16'h2004, 16'h2106, 16'h2207, 16'h2308, 16'h240a, 16'h250b, 16'h260c, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'h2b1c, 16'h2c1a, 16'h2d18, 16'h2e03, 16'h2f16,
        16'h3002, 16'h310e, 16'h320d, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h9600,
        16'h0000, 16'h3920, 16'h0000, 16'h5e00, 16'h5f00, 16'h6000, 16'h6100, 16'h6200,
        16'h6300, 16'h6400, 16'h6500, 16'h6600, 16'h6700, 16'h0000, 16'h0000, 16'h7700,
        16'h8d00, 16'h8400, 16'h8e00, 16'h7300, 16'h8f00, 16'h7400, 16'h0000, 16'h7500,
        16'h9100, 16'h7600, 16'h9200, 16'h9300
    };

    // alt keys carry only the scan byte
    localparam logic [7:0] TBL_ALT [TableLen] = '{
        8'h00, 8'h01, 8'h78, 8'h79, 8'h7a, 8'h7b, 8'h7c, 8'h7d,
        8'h7e, 8'h7f, 8'h80, 8'h81, 8'h82, 8'h83, 8'h0e, 8'ha5,
        8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17,
        8'h18, 8'h19, 8'h1a, 8'h1b, 8'ha6, 8'h00, 8'h1e, 8'h1f,
        8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
        8'h28, 8'h29, 8'h00, 8'h2b, 8'h2c, 8'h2d, 8'h2e, 8'h2f,
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h00, 8'h37,
        8'h00, 8'h39, 8'h00, 8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c,
        8'h6d, 8'h6e, 8'h6f, 8'h70, 8'h71, 8'h00, 8'h00, 8'h97,
        8'h98, 8'h99, 8'h4a, 8'h9b, 8'h9c, 8'h9d, 8'h4e, 8'h9f,
        8'ha0, 8'ha1, 8'ha2, 8'ha3
    };

endpackage

`default_nettype wire

// ----- sv/kbt_keys.sv -----
`default_nettype none

module kbt_keys (
    input  wire logic [7:0]        i_scan_code,
    input  wire logic [7:0]        i_flags,
    input  wire logic [2:0]        i_held,
    output kbt_pkg::t_kbt_dec      o_dec
);
    import kbt_pkg::*;

    logic       do_xlate;
    logic       in_table;
    logic       inv;
    logic [6:0] idx;
    logic [15:0] key;

    // modifier and lock codes
    always_comb begin
        o_dec.flags   = i_flags;
        o_dec.held    = i_held;
        o_dec.toggled = 1'b0;
        o_dec.overrun = 1'b0;
        do_xlate      = 1'b0;
        case (i_scan_code)
            SC_OVERRUN:             o_dec.overrun = 1'b1;
            SC_LSHIFT:              o_dec.flags[FL_LSHIFT] = 1'b1;
            SC_LSHIFT | SC_BREAK:   o_dec.flags[FL_LSHIFT] = 1'b0;
            SC_RSHIFT:              o_dec.flags[FL_RSHIFT] = 1'b1;
            SC_RSHIFT | SC_BREAK:   o_dec.flags[FL_RSHIFT] = 1'b0;
            SC_CTRL:                o_dec.flags[FL_CTRL] = 1'b1;
            SC_CTRL | SC_BREAK:     o_dec.flags[FL_CTRL] = 1'b0;
            SC_ALT:                 o_dec.flags[FL_ALT] = 1'b1;
            SC_ALT | SC_BREAK:      o_dec.flags[FL_ALT] = 1'b0;
            SC_CAPS: begin
                o_dec.flags[FL_CAPS] = ~i_flags[FL_CAPS];
                o_dec.held[HL_CAPS]  = 1'b1;
                o_dec.toggled        = 1'b1;
            end
            SC_CAPS | SC_BREAK:     o_dec.held[HL_CAPS] = 1'b0;
            SC_NUM: begin
                o_dec.flags[FL_NUM] = ~i_flags[FL_NUM];
                o_dec.held[HL_NUM]  = 1'b1;
                o_dec.toggled       = 1'b1;
            end
            SC_NUM | SC_BREAK:      o_dec.held[HL_NUM] = 1'b0;
            SC_SCROLL: begin
                o_dec.flags[FL_SCROLL] = ~i_flags[FL_SCROLL];
                o_dec.held[HL_SCROLL]  = 1'b1;
                o_dec.toggled          = 1'b1;
            end
            SC_SCROLL | SC_BREAK:   o_dec.held[HL_SCROLL] = 1'b0;
            default:                do_xlate = 1'b1;
        endcase
    end

    // table translation uses the flags from before this code
    always_comb begin
        idx      = i_scan_code[6:0];
        in_table = (i_scan_code < 8'(TableLen));
        inv      = 1'b0;
        if (i_scan_code >= SC_KEYPAD_LO && i_scan_code <= SC_KEYPAD_HI) begin
            inv = i_flags[FL_NUM];
        end else if ((i_scan_code >= 8'h10 && i_scan_code <= 8'h19) ||
                     (i_scan_code >= 8'h1e && i_scan_code <= 8'h26) ||
                     (i_scan_code >= 8'h2c && i_scan_code <= 8'h32)) begin
            inv = i_flags[FL_CAPS];
        end
        if (!in_table || !do_xlate) begin
            key = 16'h0000;
        end else if (i_flags[FL_ALT]) begin
            key = {TBL_ALT[idx], 8'h00};
        end else if (i_flags[FL_CTRL]) begin
            key = TBL_CTRL[idx];
        end else if (inv ^ (i_flags[FL_RSHIFT] | i_flags[FL_LSHIFT])) begin
            key = TBL_SHIFT[idx];
        end else begin
            key = TBL_PLAIN[idx];
        end
    end

    assign o_dec.key = key;

endmodule

`default_nettype wire

// ----- sv/kbt_ring.sv -----
`default_nettype none

module kbt_ring #(
    parameter int OW = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [15:0]       i_cfg_data,
    input  wire logic              i_step,
    input  wire logic              i_key_nz,
    input  wire logic [15:0]       i_head,
    output kbt_pkg::t_kbt_wr       o_wr
);
    import kbt_pkg::*;

    localparam int XW = OW + 16;

    logic [OW-1:0] r_start;
    logic [OW-1:0] r_end;
    logic [OW-1:0] r_tail;
    logic [OW-1:0] n_tail;

    logic [XW-1:0] cfg_x;
    logic [XW-1:0] head_x;
    logic [XW-1:0] tail_x;
    logic [OW-1:0] cfg_w;
    logic [OW-1:0] head_w;
    logic [OW-1:0] inc_tail;
    logic [OW-1:0] room;
    logic [OW-1:0] next_slot;
    logic          hit_head;

    assign cfg_x  = {{OW{1'b0}}, i_cfg_data};
    assign head_x = {{OW{1'b0}}, i_head};
    assign tail_x = {16'h0000, r_tail};
    assign cfg_w  = cfg_x[OW-1:0];
    assign head_w = head_x[OW-1:0];

    // wrap to start once fewer than two bytes remain before the end
    assign inc_tail  = r_tail + OW'(2);
    assign room      = r_end - inc_tail;
    assign next_slot = (room < OW'(2)) ? r_start : inc_tail;
    assign hit_head  = (next_slot == head_w);

    assign o_wr.valid  = i_key_nz && !hit_head;
    assign o_wr.full   = i_key_nz && hit_head;
    assign o_wr.offset = o_wr.valid ? tail_x[15:0] : 16'h0000;

    assign n_tail = (i_step && o_wr.valid) ? next_slot : r_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= OW'(BUFFER_START_RST);
            r_end   <= OW'(BUFFER_END_RST);
            r_tail  <= OW'(BUFFER_START_RST);
        end else begin
            r_tail <= n_tail;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BUFFER_START: r_start <= cfg_w;
                    CFG_BUFFER_END:   r_end   <= cfg_w;
                    default:          r_start <= r_start;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/keyboard_scan_code_translator.sv -----
`default_nettype none

// channel   direction  handshake                 payload
// in        to block   i_in_valid / o_in_stall   i_in_data  (scan code, head offset)
// out       from block o_out_valid / i_out_stall o_out_data (key, ring status, flags)
// cfg       to block   i_cfg_we                  i_cfg_index, i_cfg_data
//
// one request per cycle sustained while the result is not stalled; an accepted request passes
// through the input register, then decode, table lookup and tail update into the result register
// synchronous active-low reset clears flags, lock bits, valids and sets the tail to 30
// a stalled result holds the pipe; the input register still takes a request when the
// result register is free or being emptied in the same cycle

module keyboard_scan_code_translator #(
    parameter int OFFSET_WIDTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output      logic              o_in_stall,
    input  wire kbt_pkg::t_kbt_in  i_in_data,
    output      logic              o_out_valid,
    input  wire logic              i_out_stall,
    output      kbt_pkg::t_kbt_out o_out_data,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [15:0]       i_cfg_data
);
    import kbt_pkg::*;

    logic      r_in_valid;
    t_kbt_in   r_in;
    logic      r_out_valid;
    t_kbt_out  r_out;
    t_kbt_out  n_out;
    logic [7:0] r_flags;
    logic [2:0] r_held;

    t_kbt_dec  dec;
    t_kbt_wr   wr;
    logic      out_free;
    logic      step;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    kbt_keys u_keys (
        .i_scan_code (r_in.scan_code),
        .i_flags     (r_flags),
        .i_held      (r_held),
        .o_dec       (dec)
    );

    kbt_ring #(
        .OW (OFFSET_WIDTH)
    ) u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (step),
        .i_key_nz    (dec.key != 16'h0000),
        .i_head      (r_in.head_offset),
        .o_wr        (wr)
    );

    always_comb begin
        n_out.key_code     = dec.key;
        n_out.key_valid    = wr.valid;
        n_out.write_offset = wr.offset;
        n_out.buffer_full  = wr.full;
        n_out.overrun      = dec.overrun;
        n_out.shift_flags  = dec.flags;
        n_out.lock_toggled = dec.toggled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= 8'h00;
            r_held      <= 3'b000;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_flags <= dec.flags;
                r_held  <= dec.held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_data;
        end
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_store_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.key_valid && r_out.buffer_full))
        else $error("key both stored and dropped");

    a_store_has_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.key_valid || r_out.buffer_full)) |-> (r_out.key_code != 16'h0000))
        else $error("ring activity without a key");

    a_overrun_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.overrun) |->
            (r_out.key_code == 16'h0000 && !r_out.lock_toggled))
        else $error("overrun produced a key or toggle");

    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!step && $past(i_rst_n)) |=> (r_flags == $past(r_flags)))
        else $error("flags moved without a request");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none

module testbench;

    import kbt_pkg::*;

    // scan code rows whose keys follow caps lock
    localparam logic [7:0] ROW_Q_LO = 8'h10;
    localparam logic [7:0] ROW_Q_HI = 8'h19;
    localparam logic [7:0] ROW_A_LO = 8'h1e;
    localparam logic [7:0] ROW_A_HI = 8'h26;
    localparam logic [7:0] ROW_Z_LO = 8'h2c;
    localparam logic [7:0] ROW_Z_HI = 8'h32;

    localparam logic [7:0] KEY_A      = 8'h1e;
    localparam logic [7:0] KEY_HOME   = SC_KEYPAD_LO;
    localparam logic [7:0] KEY_NULL   = 8'h00;
    localparam logic [7:0] KEY_BEYOND = 8'h54;

    localparam logic [15:0] PLAIN_KEYS [TableLen] = '{
        16'h0000, 16'h011b, 16'h0231, 16'h0332, 16'h0433, 16'h0534, 16'h0635, 16'h0736,
        16'h0837, 16'h0938, 16'h0a39, 16'h0b30, 16'h0c2d, 16'h0d3d, 16'h0e08, 16'h0f09,
        16'h1071, 16'h1177, 16'h1265, 16'h1372, 16'h1474, 16'h1579, 16'h1675, 16'h1769,
        16'h186f, 16'h1970, 16'h1a5b, 16'h1b5d, 16'h1c0d, 16'h0000, 16'h1e61, 16'h1f73,
        16'h2064, 16'h2166, 16'h2267, 16'h2368, 16'h246a, 16'h256b, 16'h266c, 16'h273b,
        16'h2827, 16'h2960, 16'h0000, 16'h2b5c, 16'h2c7a, 16'h2d78, 16'h2e63, 16'h2f76,
        16'h3062, 16'h316e, 16'h326d, 16'h332c, 16'h342e, 16'h352f, 16'h0000, 16'h372a,
        16'h0000, 16'h3920, 16'h0000, 16'h3b00, 16'h3c00, 16'h3d00, 16'h3e00, 16'h3f00,
        16'h4000, 16'h4100, 16'h4200, 16'h4300, 16'h4400, 16'h0000, 16'h0000, 16'h4700,
        16'h4800, 16'h4900, 16'h4a2d, 16'h4b00, 16'h4c00, 16'h4d00, 16'h4e2b, 16'h4f00,
        16'h5000, 16'h5100, 16'h5200, 16'h5300
    };

    localparam logic [15:0] SHIFTED_KEYS [TableLen] = '{
        16'h0000, 16'h011b, 16'h0221, 16'h0340, 16'h0423, 16'h0524, 16'h0625, 16'h075e,
        16'h0826, 16'h092a, 16'h0a28, 16'h0b29, 16'h0c5f, 16'h0d2b, 16'h0e08, 16'h0f00,
        16'h1051, 16'h1157, 16'h1245, 16'h1352, 16'h1454, 16'h1559, 16'h1655, 16'h1749,
        16'h184f, 16'h1950, 16'h1a7b, 16'h1b7d, 16'h1c0d, 16'h0000, 16'h1e41, 16'h1f53,
        16'h2044, 16'h2146, 16'h2247, 16'h2348, 16'h244a, 16'h254b, 16'h264c, 16'h273a,
        16'h2822, 16'h297e, 16'h0000, 16'h2b7c, 16'h2c5a, 16'h2d58, 16'h2e43, 16'h2f56,
        16'h3042, 16'h314e, 16'h324d, 16'h333c, 16'h343e, 16'h353f, 16'h0000, 16'h0000,
        16'h0000, 16'h3920, 16'h0000, 16'h5400, 16'h5500, 16'h5600, 16'h5700, 16'h5800,
        16'h5900, 16'h5a00, 16'h5b00, 16'h5c00, 16'h5d00, 16'h0000, 16'h0000, 16'h4737,
        16'h4838, 16'h4939, 16'h4a2d, 16'h4b34, 16'h4c35, 16'h4d36, 16'h4e2b, 16'h4f31,
        16'h5032, 16'h5133, 16'h5230, 16'h532e
    };

    localparam logic [15:0] CTRL_KEYS [TableLen] = '{
        16'h0000, 16'h011b, 16'h0000, 16'h0300, 16'h0000, 16'h0000, 16'h0000, 16'h071e,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0c1f, 16'h0000, 16'h0e7f, 16'h9400,
        16'h1011, 16'h1117, 16'h1205, 16'h1312, 16'h1414, 16'h1519, 16'h1615, 16'h1709,
        16'h180f, 16'h1910, 16'h1a1b, 16'h1b1d, 16'h1c0a, 16'h0000, 16'h1e01, 16'h1f13,
        16'h2004, 16'h2106, 16'h2207, 16'h2308, 16'h240a, 16'h250b, 16'h260c, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'h2b1c, 16'h2c1a, 16'h2d18, 16'h2e03, 16'h2f16,
        16'h3002, 16'h310e, 16'h320d, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h9600,
        16'h0000, 16'h3920, 16'h0000, 16'h5e00, 16'h5f00, 16'h6000, 16'h6100, 16'h6200,
        16'h6300, 16'h6400, 16'h6500, 16'h6600, 16'h6700, 16'h0000, 16'h0000, 16'h7700,
        16'h8d00, 16'h8400, 16'h8e00, 16'h7300, 16'h8f00, 16'h7400, 16'h0000, 16'h7500,
        16'h9100, 16'h7600, 16'h9200, 16'h9300
    };

    // alt combinations produce a scan byte with an empty ascii byte
    localparam logic [7:0] ALT_SCANS [TableLen] = '{
        8'h00, 8'h01, 8'h78, 8'h79, 8'h7a, 8'h7b, 8'h7c, 8'h7d,
        8'h7e, 8'h7f, 8'h80, 8'h81, 8'h82, 8'h83, 8'h0e, 8'ha5,
        8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17,
        8'h18, 8'h19, 8'h1a, 8'h1b, 8'ha6, 8'h00, 8'h1e, 8'h1f,
        8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
        8'h28, 8'h29, 8'h00, 8'h2b, 8'h2c, 8'h2d, 8'h2e, 8'h2f,
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h00, 8'h37,
        8'h00, 8'h39, 8'h00, 8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c,
        8'h6d, 8'h6e, 8'h6f, 8'h70, 8'h71, 8'h00, 8'h00, 8'h97,
        8'h98, 8'h99, 8'h4a, 8'h9b, 8'h9c, 8'h9d, 8'h4e, 8'h9f,
        8'ha0, 8'ha1, 8'ha2, 8'ha3
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_kbt_in     i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_kbt_out    o_out_data;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = CFG_BUFFER_START;
    logic [15:0] i_cfg_data = '0;

    // keyboard state as the block should hold it
    logic [7:0]  kb_flags;
    logic [2:0]  kb_held;
    logic [15:0] ring_tail;
    logic [15:0] ring_start;
    logic [15:0] ring_end;

    t_kbt_out    pending_keys [$];
    int          error_count = 0;
    int          report_count = 0;
    int          burst_left = 0;

    keyboard_scan_code_translator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [15:0] lookup_key(input logic [7:0] code);
        logic invert;
        invert = 1'b0;
        if (code >= TableLen) return 16'h0000;
        if (code >= SC_KEYPAD_LO && code <= SC_KEYPAD_HI)
            invert = kb_flags[FL_NUM];
        else if ((code >= ROW_Q_LO && code <= ROW_Q_HI) ||
                 (code >= ROW_A_LO && code <= ROW_A_HI) ||
                 (code >= ROW_Z_LO && code <= ROW_Z_HI))
            invert = kb_flags[FL_CAPS];
        if (kb_flags[FL_ALT]) return {ALT_SCANS[code], 8'h00};
        if (kb_flags[FL_CTRL]) return CTRL_KEYS[code];
        if (kb_flags[FL_LSHIFT] || kb_flags[FL_RSHIFT]) invert = ~invert;
        return invert ? SHIFTED_KEYS[code] : PLAIN_KEYS[code];
    endfunction

    function automatic logic [15:0] next_tail();
        logic [15:0] nt;
        logic [15:0] room;
        nt = ring_tail + 16'd2;
        room = ring_end - nt;
        if (room < 16'd2) nt = ring_start;
        return nt;
    endfunction

    // advance the keyboard state by one scan code and return the result it gives
    function automatic t_kbt_out apply_scan(input t_kbt_in req);
        t_kbt_out res;
        logic [15:0] nt;
        res = '0;
        case (req.scan_code)
            SC_OVERRUN:            res.overrun = 1'b1;
            SC_LSHIFT:             kb_flags[FL_LSHIFT] = 1'b1;
            SC_LSHIFT | SC_BREAK:  kb_flags[FL_LSHIFT] = 1'b0;
            SC_RSHIFT:             kb_flags[FL_RSHIFT] = 1'b1;
            SC_RSHIFT | SC_BREAK:  kb_flags[FL_RSHIFT] = 1'b0;
            SC_CTRL:               kb_flags[FL_CTRL] = 1'b1;
            SC_CTRL | SC_BREAK:    kb_flags[FL_CTRL] = 1'b0;
            SC_ALT:                kb_flags[FL_ALT] = 1'b1;
            SC_ALT | SC_BREAK:     kb_flags[FL_ALT] = 1'b0;
            SC_CAPS: begin
                kb_flags[FL_CAPS] = ~kb_flags[FL_CAPS];
                kb_held[HL_CAPS] = 1'b1;
                res.lock_toggled = 1'b1;
            end
            SC_CAPS | SC_BREAK:    kb_held[HL_CAPS] = 1'b0;
            SC_NUM: begin
                kb_flags[FL_NUM] = ~kb_flags[FL_NUM];
                kb_held[HL_NUM] = 1'b1;
                res.lock_toggled = 1'b1;
            end
            SC_NUM | SC_BREAK:     kb_held[HL_NUM] = 1'b0;
            SC_SCROLL: begin
                kb_flags[FL_SCROLL] = ~kb_flags[FL_SCROLL];
                kb_held[HL_SCROLL] = 1'b1;
                res.lock_toggled = 1'b1;
            end
            SC_SCROLL | SC_BREAK:  kb_held[HL_SCROLL] = 1'b0;
            default:               res.key_code = lookup_key(req.scan_code);
        endcase
        if (res.key_code != 16'h0000) begin
            nt = next_tail();
            if (nt == req.head_offset) begin
                res.buffer_full = 1'b1;
            end else begin
                res.key_valid = 1'b1;
                res.write_offset = ring_tail;
                ring_tail = nt;
            end
        end
        res.shift_flags = kb_flags;
        return res;
    endfunction

    task automatic send_key(input logic [7:0] code, input logic [15:0] head);
        t_kbt_in req;
        req.scan_code = code;
        req.head_offset = head;
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (o_in_stall);
        pending_keys.push_back(apply_scan(req));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(0, 8);
        end
    endtask

    // hold off new requests until every expected result has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_keys.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_ring(input logic [15:0] first, input logic [15:0] past_last);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_BUFFER_START;
        i_cfg_data <= first;
        @(posedge i_clk);
        ring_start = first;
        i_cfg_index <= CFG_BUFFER_END;
        i_cfg_data <= past_last;
        @(posedge i_clk);
        ring_end = past_last;
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_overrun_and_unknown();
        send_key(SC_OVERRUN, 16'hffff);
        send_key(KEY_NULL, 16'h0000);
        send_key(KEY_BEYOND, ring_tail);
        send_key(KEY_A | SC_BREAK, ring_tail);
        send_key(KEY_A, ring_tail);
        drain();
    endtask

    task automatic test_modifier_keys();
        send_key(SC_LSHIFT, ring_tail);
        send_key(KEY_A, ring_tail);
        send_key(SC_RSHIFT, ring_tail);
        send_key(SC_RSHIFT | SC_BREAK, ring_tail);
        send_key(SC_LSHIFT | SC_BREAK, ring_tail);
        // ctrl, then alt on top of it
        send_key(SC_CTRL, ring_tail);
        send_key(KEY_A, ring_tail);
        send_key(SC_ALT, ring_tail);
        send_key(KEY_A, ring_tail);
        send_key(SC_ALT | SC_BREAK, ring_tail);
        send_key(SC_CTRL | SC_BREAK, ring_tail);
        drain();
    endtask

    task automatic test_lock_keys();
        send_key(SC_CAPS, ring_tail);
        send_key(KEY_A, ring_tail);
        send_key(SC_CAPS | SC_BREAK, ring_tail);
        send_key(SC_NUM, ring_tail);
        send_key(KEY_HOME, ring_tail);
        send_key(SC_NUM | SC_BREAK, ring_tail);
        send_key(SC_SCROLL, ring_tail);
        send_key(SC_SCROLL | SC_BREAK, ring_tail);
        drain();
    endtask

    // two slots left before the end, then wrap to a start elsewhere;
    // the tail itself stays where it was across the register writes
    task automatic test_ring_wrap_and_full();
        set_ring(16'h0100, ring_tail + 16'd4);
        send_key(KEY_A, 16'h0000);
        send_key(KEY_A, 16'h0100);
        send_key(KEY_A, 16'h0000);
        send_key(KEY_A, 16'h0102);
        drain();
    endtask

    task automatic test_random_typing();
        logic [7:0]  code;
        logic [15:0] head;
        logic [15:0] first;
        logic [15:0] past_last;
        int          pick;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    first = BUFFER_START_RST;
                    past_last = BUFFER_END_RST;
                end
                1: begin
                    first = 16'h0000;
                    past_last = 16'h0000;
                end
                2: begin
                    first = 16'hffff;
                    past_last = 16'hffff;
                end
                3: begin
                    first = 16'h0000;
                    past_last = 16'hffff;
                end
                4: begin
                    first = 16'hffff;
                    past_last = 16'h0000;
                end
                default: begin
                    // small ring around the current tail so wrap and full come often
                    past_last = ring_tail + 16'(2 * $urandom_range(1, 8))
                              + 16'($urandom_range(0, 1));
                    first = ($urandom_range(0, 2) != 0)
                          ? ring_tail - 16'(2 * $urandom_range(0, 6))
                          : 16'($urandom);
                end
            endcase
            set_ring(first, past_last);
            for (int n = 0; n < 165; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    code = 8'($urandom_range(0, TableLen - 1));
                end else if (pick < 68) begin
                    case ($urandom_range(0, 3))
                        0: code = SC_CTRL;
                        1: code = SC_LSHIFT;
                        2: code = SC_RSHIFT;
                        default: code = SC_ALT;
                    endcase
                    if (pick >= 55) code = code | SC_BREAK;
                end else if (pick < 80) begin
                    case ($urandom_range(0, 2))
                        0: code = SC_CAPS;
                        1: code = SC_NUM;
                        default: code = SC_SCROLL;
                    endcase
                    if (pick >= 74) code = code | SC_BREAK;
                end else if (pick < 88) begin
                    code = 8'($urandom_range(0, 127)) | SC_BREAK;
                end else if (pick < 91) begin
                    code = SC_OVERRUN;
                end else begin
                    code = 8'($urandom);
                end
                case ($urandom_range(0, 9))
                    0, 1, 2: head = next_tail();
                    3:       head = ring_tail;
                    8:       head = ring_start;
                    9:       head = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
                    default: head = 16'($urandom);
                endcase
                send_key(code, head);
            end
            drain();
        end
    endtask

    // receiver back-pressure: quiet, light, heavy and long-run stall stretches
    initial begin : stall_pattern
        int mode;
        int run;
        mode = 0;
        run = 0;
        forever begin
            @(posedge i_clk);
            if (run == 0) begin
                mode = $urandom_range(0, 3);
                run = $urandom_range(20, 150);
            end else begin
                run--;
            end
            case (mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 4) != 0);
                default: i_out_stall <= (((run / 8) % 2) == 1);
            endcase
        end
    end

    always @(posedge i_clk) begin : check_results
        t_kbt_out want;
        string    diff;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_keys.size() == 0) begin
                error_count++;
                report_count++;
                if (report_count <= 10)
                    $display("unexpected result at %0t: key=%h", $time, o_out_data.key_code);
            end else begin
                want = pending_keys.pop_front();
                diff = "";
                if (o_out_data.key_code !== want.key_code) diff = {diff, " key_code"};
                if (o_out_data.key_valid !== want.key_valid) diff = {diff, " key_valid"};
                if (o_out_data.write_offset !== want.write_offset)
                    diff = {diff, " write_offset"};
                if (o_out_data.buffer_full !== want.buffer_full) diff = {diff, " buffer_full"};
                if (o_out_data.overrun !== want.overrun) diff = {diff, " overrun"};
                if (o_out_data.shift_flags !== want.shift_flags) diff = {diff, " shift_flags"};
                if (o_out_data.lock_toggled !== want.lock_toggled)
                    diff = {diff, " lock_toggled"};
                if (diff != "") begin
                    error_count++;
                    report_count++;
                    if (report_count <= 10) begin
                        $display("mismatch at %0t in%s", $time, diff);
                        $display("  expected key=%h valid=%b ofs=%h full=%b ovr=%b flags=%h tog=%b",
                                 want.key_code, want.key_valid, want.write_offset,
                                 want.buffer_full, want.overrun, want.shift_flags,
                                 want.lock_toggled);
                        $display("  got      key=%h valid=%b ofs=%h full=%b ovr=%b flags=%h tog=%b",
                                 o_out_data.key_code, o_out_data.key_valid,
                                 o_out_data.write_offset, o_out_data.buffer_full,
                                 o_out_data.overrun, o_out_data.shift_flags,
                                 o_out_data.lock_toggled);
                    end
                end
            end
        end
    end

    initial begin
        kb_flags = '0;
        kb_held = '0;
        ring_tail = BUFFER_START_RST;
        ring_start = BUFFER_START_RST;
        ring_end = BUFFER_END_RST;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_overrun_and_unknown();
        test_modifier_keys();
        test_lock_keys();
        test_ring_wrap_and_full();
        test_random_typing();
        drain();
        repeat (4) @(posedge i_clk);
        error_count += pending_keys.size();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
sv/kbt_pkg.sv
sv/kbt_keys.sv
sv/kbt_ring.sv
sv/keyboard_scan_code_translator.sv
tb/testbench.sv
